@@ sv/qrs_pkg.sv @@
// Shared types, widths, status codes and helpers of the quadratic root solver.
package qrs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW        = 32;
    localparam int EPS_W     = 31;
    localparam int MAG_W     = CW;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int DISC_W    = PROD_W + 3;
    localparam int RAD_W     = PROD_W + 2;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int SQ_W      = RAD_W + 2;
    localparam int NUM_W     = ROOT_W + 2;
    localparam int DIVD_W    = NUM_W + FRAC_BITS;
    localparam int DEN_W     = MAG_W + 1;
    localparam int QW        = CW;
    localparam int REM_W     = DEN_W + QW;
    localparam int THR_W     = EPS_W + FRAC_BITS;

    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_ONE     = 3'd1;
    localparam logic [2:0] ST_TWO     = 3'd2;
    localparam logic [2:0] ST_LINEAR  = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    typedef struct packed {
        logic signed [CW-1:0] coef_a;
        logic signed [CW-1:0] coef_b;
        logic signed [CW-1:0] coef_c;
    } qrs_in_t;

    typedef struct packed {
        logic [2:0]           root_status;
        logic signed [CW-1:0] root_one;
        logic signed [CW-1:0] root_two;
        logic                 saturated;
    } qrs_out_t;

    typedef struct packed {
        logic [2:0]       status;
        logic             neg1;
        logic [MAG_W-1:0] num1;
        logic [DEN_W-1:0] den;
        logic             bn;
        logic             an;
    } qrs_side_t;

    typedef struct packed {
        logic [2:0] status;
        logic       neg1;
        logic       neg2;
    } qrs_dside_t;

    typedef struct packed {
        logic [NUM_W-1:0] num1;
        logic [NUM_W-1:0] num2;
        logic [DEN_W-1:0] den;
        qrs_dside_t       side;
    } qrs_div_in_t;

    typedef struct packed {
        logic [QW-1:0] q1;
        logic [QW-1:0] q2;
        logic          ovf1;
        logic          ovf2;
        qrs_dside_t    side;
    } qrs_quot_t;

    function automatic logic [MAG_W-1:0] mag_of(logic [CW-1:0] v);
        return v[CW-1] ? (~v + 1'b1) : v;
    endfunction

    // {saturated, root}
    function automatic logic [CW:0] clamp_root(logic neg, logic ovf, logic [QW-1:0] q);
        logic big;
        logic [QW-1:0] lim;
        lim = {1'b1, {(QW-1){1'b0}}};
        if (!neg) begin
            big = ovf || q[QW-1];
            return big ? {1'b1, 1'b0, {(CW-1){1'b1}}} : {1'b0, q};
        end
        big = ovf || (q > lim);
        return big ? {1'b1, lim} : {1'b0, (~q + 1'b1)};
    endfunction

endpackage

@@ sv/qrs_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, with sideband.
module qrs_sqrt import qrs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  in_rad,
    input  qrs_side_t         in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output qrs_side_t         out_side
);

    typedef struct packed {
        logic [SQ_W-1:0]   rem;
        logic [ROOT_W-1:0] res;
        qrs_side_t         side;
    } sq_stage_t;

    logic [ROOT_W-1:0] v_reg;
    sq_stage_t         st_reg  [ROOT_W];
    sq_stage_t         st_next [ROOT_W];
    sq_stage_t         src     [ROOT_W];

    always_comb begin
        logic [SQ_W-1:0] t;
        int              b;
        src[0].rem  = {2'b00, in_rad};
        src[0].res  = '0;
        src[0].side = in_side;
        for (int k = 1; k < ROOT_W; k++) begin
            src[k] = st_reg[k-1];
        end
        for (int k = 0; k < ROOT_W; k++) begin
            b = ROOT_W - 1 - k;
            t = ({{(SQ_W-ROOT_W){1'b0}}, src[k].res} << (b + 1))
                + ({{(SQ_W-1){1'b0}}, 1'b1} << (2 * b));
            st_next[k] = src[k];
            if (src[k].rem >= t) begin
                st_next[k].rem    = src[k].rem - t;
                st_next[k].res[b] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[ROOT_W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < ROOT_W; k++) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_root  = st_reg[ROOT_W-1].res;
    assign out_side  = st_reg[ROOT_W-1].side;

endmodule

@@ sv/qrs_div.sv @@
// Two-lane pipelined restoring divider of (num << FRAC_BITS) by a shared divisor.
module qrs_div import qrs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        adv,
    input  logic        in_valid,
    input  qrs_div_in_t in_data,
    output logic        out_valid,
    output qrs_quot_t   out_data
);

    localparam int NST = QW + 1;

    typedef struct packed {
        logic [REM_W-1:0] rem1;
        logic [REM_W-1:0] rem2;
        logic [QW-1:0]    q1;
        logic [QW-1:0]    q2;
        logic             ovf1;
        logic             ovf2;
        logic [DEN_W-1:0] den;
        qrs_dside_t       side;
    } dv_stage_t;

    logic [NST-1:0] v_reg;
    dv_stage_t      st_reg  [NST];
    dv_stage_t      st_next [NST];

    always_comb begin
        logic [REM_W-1:0] n1;
        logic [REM_W-1:0] n2;
        logic [REM_W-1:0] dtop;
        logic [REM_W-1:0] dsh;
        int               b;
        n1   = {{(REM_W-DIVD_W){1'b0}}, in_data.num1, {FRAC_BITS{1'b0}}};
        n2   = {{(REM_W-DIVD_W){1'b0}}, in_data.num2, {FRAC_BITS{1'b0}}};
        dtop = {in_data.den, {QW{1'b0}}};
        st_next[0].rem1 = n1;
        st_next[0].rem2 = n2;
        st_next[0].q1   = '0;
        st_next[0].q2   = '0;
        st_next[0].ovf1 = (n1 >= dtop);
        st_next[0].ovf2 = (n2 >= dtop);
        st_next[0].den  = in_data.den;
        st_next[0].side = in_data.side;
        for (int k = 1; k < NST; k++) begin
            b   = QW - k;
            dsh = {{QW{1'b0}}, st_reg[k-1].den} << b;
            st_next[k] = st_reg[k-1];
            if (!st_reg[k-1].ovf1 && st_reg[k-1].rem1 >= dsh) begin
                st_next[k].rem1  = st_reg[k-1].rem1 - dsh;
                st_next[k].q1[b] = 1'b1;
            end
            if (!st_reg[k-1].ovf2 && st_reg[k-1].rem2 >= dsh) begin
                st_next[k].rem2  = st_reg[k-1].rem2 - dsh;
                st_next[k].q2[b] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NST; k++) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid     = v_reg[NST-1];
    assign out_data.q1   = st_reg[NST-1].q1;
    assign out_data.q2   = st_reg[NST-1].q2;
    assign out_data.ovf1 = st_reg[NST-1].ovf1;
    assign out_data.ovf2 = st_reg[NST-1].ovf2;
    assign out_data.side = st_reg[NST-1].side;

endmodule

@@ sv/quadratic_root_solver.sv @@
// Top level of the quadratic root solver: operand prep, discriminant, root and divide pipes.
// One coefficient word enters per cycle while the pipe is not held; its result word passes through
// 4 front stages, 33 square-root and 33 divide stages (one result bit per stage), 1 numerator
// stage and the output register. When the result word is not taken the whole pipe holds, so
// s_ready follows !m_valid || m_ready. The user must write the epsilon register only while
// the pipe is empty; the block itself does not enforce this.
module quadratic_root_solver import qrs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [EPS_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  qrs_in_t          s_data,
    input  logic             m_ready,
    output logic             m_valid,
    output qrs_out_t         m_data
);

    typedef struct packed {
        logic [MAG_W-1:0] am;
        logic [MAG_W-1:0] bm;
        logic [MAG_W-1:0] cm;
        logic             an;
        logic             bn;
        logic             cn;
        logic             asmall;
        logic             bsmall;
        logic [THR_W-1:0] thr;
    } ops_t;

    logic [EPS_W-1:0] eps_reg;
    logic [EPS_W-1:0] eff_eps;
    logic             adv;

    logic                     a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg;
    ops_t                     a_reg, a_next;
    ops_t                     b_ops_reg, c_ops_reg;
    logic [PROD_W-1:0]        bb_reg, p_reg;
    logic signed [DISC_W-1:0] d_reg, d_next;
    logic [RAD_W-1:0]         rad_reg, rad_next;
    qrs_side_t                side_reg, side_next;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    qrs_side_t         sq_side;
    qrs_div_in_t       div_in_reg, div_in_next;
    logic              dv_valid;
    qrs_quot_t         dv_data;
    qrs_out_t          out_reg, out_next;
    logic              out_v_reg;

    assign adv     = !out_v_reg || m_ready;
    assign s_ready = adv;
    assign eff_eps = (eps_reg == '0) ? {{(EPS_W-1){1'b0}}, 1'b1} : eps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= {{(EPS_W-1){1'b0}}, 1'b1};
        end else if (cfg_we) begin
            eps_reg <= cfg_wdata;
        end
    end

    always_comb begin
        a_next.am     = mag_of(s_data.coef_a);
        a_next.bm     = mag_of(s_data.coef_b);
        a_next.cm     = mag_of(s_data.coef_c);
        a_next.an     = s_data.coef_a[CW-1];
        a_next.bn     = s_data.coef_b[CW-1];
        a_next.cn     = s_data.coef_c[CW-1];
        a_next.asmall = a_next.am < {{(MAG_W-EPS_W){1'b0}}, eff_eps};
        a_next.bsmall = a_next.bm < {{(MAG_W-EPS_W){1'b0}}, eff_eps};
        a_next.thr    = {eff_eps, {FRAC_BITS{1'b0}}};
    end

    always_comb begin
        logic [DISC_W-1:0] bbx;
        logic [DISC_W-1:0] p4;
        bbx = {3'b000, bb_reg};
        p4  = {1'b0, p_reg, 2'b00};
        d_next = (b_ops_reg.an ^ b_ops_reg.cn) ? $signed(bbx + p4) : $signed(bbx - p4);
    end

    always_comb begin
        logic signed [DISC_W-1:0] thr_s;
        logic [DISC_W-1:0]        dabs;
        logic                     two;
        logic                     one;
        thr_s = $signed({{(DISC_W-THR_W){1'b0}}, c_ops_reg.thr});
        dabs  = d_reg[DISC_W-1] ? -d_reg : d_reg;
        two   = !d_reg[DISC_W-1] && (d_reg > thr_s);
        one   = dabs < $unsigned(thr_s);
        side_next.bn = c_ops_reg.bn;
        side_next.an = c_ops_reg.an;
        if (c_ops_reg.asmall) begin
            side_next.status = c_ops_reg.bsmall ? ST_INVALID : ST_LINEAR;
            side_next.neg1   = ~c_ops_reg.cn ^ c_ops_reg.bn;
            side_next.num1   = c_ops_reg.cm;
            side_next.den    = {1'b0, c_ops_reg.bm};
        end else begin
            side_next.status = two ? ST_TWO : (one ? ST_ONE : ST_NONE);
            side_next.neg1   = ~c_ops_reg.bn ^ c_ops_reg.an;
            side_next.num1   = c_ops_reg.bm;
            side_next.den    = {c_ops_reg.am, 1'b0};
        end
        rad_next = (!c_ops_reg.asmall && two) ? d_reg[RAD_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end else if (adv) begin
            a_v_reg <= s_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg      <= a_next;
            b_ops_reg  <= a_reg;
            bb_reg     <= a_reg.bm * a_reg.bm;
            p_reg      <= a_reg.am * a_reg.cm;
            c_ops_reg  <= b_ops_reg;
            d_reg      <= d_next;
            side_reg   <= side_next;
            rad_reg    <= rad_next;
            div_in_reg <= div_in_next;
        end
    end

    qrs_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (d_v_reg),
        .in_rad    (rad_reg),
        .in_side   (side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    always_comb begin
        logic signed [NUM_W-1:0] nb;
        logic signed [NUM_W-1:0] sx;
        logic signed [NUM_W-1:0] n1;
        logic signed [NUM_W-1:0] n2;
        nb = sq_side.bn ? $signed({{(NUM_W-MAG_W){1'b0}}, sq_side.num1})
                        : -$signed({{(NUM_W-MAG_W){1'b0}}, sq_side.num1});
        sx = $signed({{(NUM_W-ROOT_W){1'b0}}, sq_root});
        n1 = nb + sx;
        n2 = nb - sx;
        div_in_next.den         = sq_side.den;
        div_in_next.side.status = sq_side.status;
        if (sq_side.status == ST_TWO) begin
            div_in_next.num1      = n1[NUM_W-1] ? $unsigned(-n1) : $unsigned(n1);
            div_in_next.num2      = n2[NUM_W-1] ? $unsigned(-n2) : $unsigned(n2);
            div_in_next.side.neg1 = n1[NUM_W-1] ^ sq_side.an;
            div_in_next.side.neg2 = n2[NUM_W-1] ^ sq_side.an;
        end else begin
            div_in_next.num1      = {{(NUM_W-MAG_W){1'b0}}, sq_side.num1};
            div_in_next.num2      = '0;
            div_in_next.side.neg1 = sq_side.neg1;
            div_in_next.side.neg2 = 1'b0;
        end
    end

    qrs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (e_v_reg),
        .in_data   (div_in_reg),
        .out_valid (dv_valid),
        .out_data  (dv_data)
    );

    always_comb begin
        logic [CW:0] c1;
        logic [CW:0] c2;
        c1 = clamp_root(dv_data.side.neg1, dv_data.ovf1, dv_data.q1);
        c2 = clamp_root(dv_data.side.neg2, dv_data.ovf2, dv_data.q2);
        out_next.root_status = dv_data.side.status;
        out_next.root_one    = '0;
        out_next.root_two    = '0;
        out_next.saturated   = 1'b0;
        case (dv_data.side.status) inside
            ST_ONE, ST_LINEAR: begin
                out_next.root_one  = $signed(c1[CW-1:0]);
                out_next.saturated = c1[CW];
            end
            ST_TWO: begin
                out_next.root_one  = $signed(c1[CW-1:0]);
                out_next.root_two  = $signed(c2[CW-1:0]);
                out_next.saturated = c1[CW] | c2[CW];
            end
            default: begin
                out_next.saturated = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (adv) begin
            out_v_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_no_root_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.root_status == ST_NONE || m_data.root_status == ST_INVALID)
        |-> (m_data.root_one == '0) && !m_data.saturated)
        else $error("root or flag set without a root");

    a_two_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.root_status != ST_TWO) |-> (m_data.root_two == '0))
        else $error("second root set without two roots");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data) && $stable(a_v_reg))
        else $error("pipe advanced while result word stalled");
`endif

endmodule
